FILE: hw/rtl/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescape block.
package jsu_pkg;

   // Parser phase, one-hot.
   typedef enum logic [3:0] {
      PH_WAIT = 4'b0001,
      PH_STR  = 4'b0010,
      PH_ESC  = 4'b0100,
      PH_HEX  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_OPEN_QUOTE = 2'd1,
      ERR_ESCAPE     = 2'd2,
      ERR_HEX        = 2'd3
   } err_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   localparam logic [7:0] BS_CODE  = 8'h08;
   localparam logic [7:0] FF_CODE  = 8'h0c;
   localparam logic [7:0] LF_CODE  = 8'h0a;
   localparam logic [7:0] CR_CODE  = 8'h0d;
   localparam logic [7:0] TAB_CODE = 8'h09;

   localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD3 = 8'he0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   localparam int unsigned MAX_RESULTS = 3;

   // Results caused by one input byte.
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][7:0]  data;
      kind_type                     kind;
      err_type                      err;
   } bundle_type;

   // Hex digit decode: valid flag in bit 4, value in bits 3:0.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/jsu_decode.sv
// Parser state and per-byte decode into a bundle of up to three results.
module jsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         in_byte,
   output jsu_pkg::bundle_type bundle
);
   import jsu_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_point_ff, code_point_in;
   logic [4:0]  hex;
   logic [15:0] cp_next;

   assign hex     = hex_digit(in_byte);
   assign cp_next = {code_point_ff[11:0], hex[3:0]};

   always_comb begin
      phase_in      = phase_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      bundle        = '0;
      bundle.kind   = KIND_BYTE;
      bundle.err    = ERR_NONE;
      case (phase_ff)
         PH_WAIT: begin
            if (in_byte == CH_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               bundle.count = 2'd1;
               bundle.kind  = KIND_ERR;
               bundle.err   = ERR_OPEN_QUOTE;
            end
         end
         PH_STR: begin
            if (in_byte == CH_BACKSLASH) begin
               phase_in = PH_ESC;
            end else if (in_byte == CH_QUOTE) begin
               bundle.count = 2'd1;
               bundle.kind  = KIND_END;
               phase_in     = PH_WAIT;
            end else begin
               bundle.count   = 2'd1;
               bundle.data[0] = in_byte;
            end
         end
         PH_ESC: begin
            phase_in     = PH_STR;
            bundle.count = 2'd1;
            case (in_byte)
               CH_QUOTE:     bundle.data[0] = CH_QUOTE;
               CH_BACKSLASH: bundle.data[0] = CH_BACKSLASH;
               CH_SLASH:     bundle.data[0] = CH_SLASH;
               CH_B:         bundle.data[0] = BS_CODE;
               CH_F:         bundle.data[0] = FF_CODE;
               CH_N:         bundle.data[0] = LF_CODE;
               CH_R:         bundle.data[0] = CR_CODE;
               CH_T:         bundle.data[0] = TAB_CODE;
               CH_U: begin
                  bundle.count  = 2'd0;
                  phase_in      = PH_HEX;
                  hex_count_in  = 2'd0;
                  code_point_in = 16'd0;
               end
               default: begin
                  bundle.kind = KIND_ERR;
                  bundle.err  = ERR_ESCAPE;
                  phase_in    = PH_WAIT;
               end
            endcase
         end
         PH_HEX: begin
            if (!hex[4]) begin
               bundle.count  = 2'd1;
               bundle.kind   = KIND_ERR;
               bundle.err    = ERR_HEX;
               phase_in      = PH_WAIT;
               hex_count_in  = 2'd0;
               code_point_in = 16'd0;
            end else if (hex_count_ff == 2'd3) begin
               // Fourth digit: encode the code point as UTF-8.
               if (cp_next[15:7] == '0) begin
                  bundle.count   = 2'd1;
                  bundle.data[0] = cp_next[7:0];
               end else if (cp_next[15:11] == '0) begin
                  bundle.count   = 2'd2;
                  bundle.data[0] = UTF8_LEAD2 | {3'b000, cp_next[10:6]};
                  bundle.data[1] = UTF8_CONT | {2'b00, cp_next[5:0]};
               end else begin
                  bundle.count   = 2'd3;
                  bundle.data[0] = UTF8_LEAD3 | {4'b0000, cp_next[15:12]};
                  bundle.data[1] = UTF8_CONT | {2'b00, cp_next[11:6]};
                  bundle.data[2] = UTF8_CONT | {2'b00, cp_next[5:0]};
               end
               phase_in      = PH_STR;
               hex_count_in  = 2'd0;
               code_point_in = 16'd0;
            end else begin
               hex_count_in  = hex_count_ff + 2'd1;
               code_point_in = cp_next;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         hex_count_ff  <= 2'd0;
         code_point_ff <= 16'd0;
      end else if (take) begin
         phase_ff      <= phase_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
      end
   end

endmodule

FILE: hw/rtl/jsu_emit.sv
// Result register: holds one bundle and hands its entries out one per transfer.
module jsu_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::bundle_type bundle,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_kind,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_last
);
   import jsu_pkg::*;

   bundle_type bundle_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       sent;
   logic       final_sent;

   assign rsp_last   = (idx_ff == bundle_ff.count - 2'd1);
   assign sent       = valid_ff && !rsp_stall;
   assign final_sent = sent && rsp_last;
   assign free       = !valid_ff || final_sent;

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = bundle_ff.kind;
   assign rsp_error_code = bundle_ff.err;

   always_comb begin
      case (idx_ff)
         2'd1:    rsp_out_byte = bundle_ff.data[1];
         2'd2:    rsp_out_byte = bundle_ff.data[2];
         default: rsp_out_byte = bundle_ff.data[0];
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (final_sent) begin
         valid_in = 1'b0;
      end else if (sent) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule

FILE: hw/rtl/json_string_unescape_core.sv
// Top level of the streaming JSON string literal unescaper.
//
//   channel | direction | ports                                         | meaning
//   req     | in        | req_valid, req_stall, req_in_byte             | raw literal byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_out_byte, rsp_kind, | decoded byte,
//           |           | rsp_error_code, rsp_last                      | end or error
//
// One input byte is taken per cycle while req_stall is low. Each byte is
// decoded in the cycle of its transfer and its results (zero to three) land in
// the result register. A byte whose results are still being handed out holds
// off the next byte until its last result leaves: a \u escape that encodes to
// three UTF-8 bytes occupies the result register until all three have left.
// Synchronous active-high reset returns the parser to waiting for an
// opening quote and empties the result register. rsp_stall holds the current
// result and, once the register cannot drain, backs up into req_stall.
module json_string_unescape_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last
);
   import jsu_pkg::*;

   bundle_type bundle;
   logic       free;
   logic       take;
   logic       load;

   // Accept a byte whenever the result register is empty or its last entry
   // leaves in this cycle.
   assign req_stall = !free;
   assign take      = req_valid && free;
   // Drop bundles with no results; the parser state still advances.
   assign load      = take && (bundle.count != 2'd0);

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .bundle  (bundle)
   );

   jsu_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .bundle         (bundle),
      .free           (free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   // A new byte never lands on top of results still owed.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && rsp_valid) |-> (!rsp_stall && rsp_last))
      else $error("input transfer while results still pending");

   // End and error results stand alone.
   a_single_nonbyte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> rsp_last)
      else $error("end or error result not last");

   // Error code present exactly on error results.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERR) == (rsp_error_code != ERR_NONE)))
      else $error("error code mismatch with kind");

   // Non-byte results carry a zero data byte.
   a_nonbyte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_out_byte == 8'd0))
      else $error("end or error result with data");

endmodule
